// ===== design/apf_pkg.sv =====
// Shared types and constants for the articulation point finder.
package apf_pkg;

  localparam int DEF_MAX_NODES = 1024;
  localparam int DEF_MAX_EDGES = 4096;

  localparam int NODE_W = 10;
  localparam int CUR_W  = 14;
  localparam int TIME_W = 11;
  localparam int CNT_W  = 11;
  localparam int WIDX_W = 4;
  localparam int FLAG_W = 64;
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 72;

  localparam logic [CUR_W-1:0] NIL_LINK = 14'h3FFF;

  // Input kind carried on tuser
  localparam logic ACT_ADD = 1'b0;
  localparam logic ACT_RUN = 1'b1;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_ADD_A, ST_ADD_A2, ST_ADD_B, ST_ADD_B2,
    ST_ROOT, ST_ROOT_CHK, ST_SCAN, ST_EDGE, ST_NODE, ST_POP, ST_POP2,
    ST_GATHER, ST_OUT
  } apf_state_t;

  // One entry of the walk stack
  typedef struct packed {
    logic [NODE_W-1:0] node;
    logic [CUR_W-1:0]  cur;
    logic [NODE_W-1:0] parent;
    logic [TIME_W-1:0] entry_t;
    logic [TIME_W-1:0] low_t;
    logic              cut;
  } stk_ent_t;

  // Per-node record
  typedef struct packed {
    logic              visited;
    logic              cut;
    logic [TIME_W-1:0] entry_t;
  } node_ent_t;

  // Adjacency slot
  typedef struct packed {
    logic [NODE_W-1:0] far;
    logic [CUR_W-1:0]  next;
  } slot_ent_t;

  // Flag word offered by the core
  typedef struct packed {
    logic              vld;
    logic [WIDX_W-1:0] idx;
    logic [FLAG_W-1:0] flags;
    logic              ovf;
    logic              last;
  } word_res_t;

endpackage

// ===== design/apf_ram.sv =====
// Generic simple dual-port RAM with registered read.
module apf_ram #(
  parameter int W = 8,
  parameter int D = 16
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);

  logic [W-1:0] mem [D];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/apf_core.sv =====
// Edge store, depth-first walk sequencer and flag word gathering.
module apf_core
  import apf_pkg::*;
#(
  parameter int MAX_NODES = DEF_MAX_NODES,
  parameter int MAX_EDGES = DEF_MAX_EDGES
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_vld,
  input  logic              in_act,
  input  logic [NODE_W-1:0] in_a,
  input  logic [NODE_W-1:0] in_b,
  input  logic [CNT_W-1:0]  nc,
  output logic              in_rdy,
  output word_res_t         res,
  input  logic              res_take
);

  localparam int SLOTS = 2 * MAX_EDGES;
  localparam int NA    = $clog2(MAX_NODES);
  localparam int SA    = $clog2(SLOTS);

  apf_state_t        st_r, st_nxt;
  logic [NODE_W-1:0] a_r, a_nxt, b_r, b_nxt, v_r, v_nxt;
  logic [CUR_W-1:0]  fill_r, fill_nxt;
  logic              drop_r, drop_nxt;
  logic [TIME_W-1:0] clk_r, clk_nxt, lowu_r, lowu_nxt;
  logic [CNT_W-1:0]  rcc_r, rcc_nxt, root_r, root_nxt;
  logic [NA-1:0]     sp_r, sp_nxt;
  logic [NA:0]       clr_r, clr_nxt;
  stk_ent_t          top_r, top_nxt;
  logic [WIDX_W-1:0] gw_r, gw_nxt;
  logic [6:0]        gc_r, gc_nxt;
  logic [FLAG_W-1:0] flags_r, flags_nxt;

  // memory ports
  logic              h_we, n_we, s_we, k_we;
  logic [NA-1:0]     h_wa, h_ra, n_wa, n_ra, k_wa, k_ra;
  logic [SA-1:0]     s_wa, s_ra;
  logic [CUR_W-1:0]  h_wd, h_rd;
  node_ent_t         n_wd, n_rd;
  slot_ent_t         s_wd, s_rd;
  stk_ent_t          k_wd, k_rd;

  apf_ram #(.W(CUR_W), .D(MAX_NODES)) u_head (
    .clk(clk), .we(h_we), .waddr(h_wa), .wdata(h_wd), .raddr(h_ra), .rdata(h_rd));
  apf_ram #(.W($bits(node_ent_t)), .D(MAX_NODES)) u_node (
    .clk(clk), .we(n_we), .waddr(n_wa), .wdata(n_wd), .raddr(n_ra), .rdata(n_rd));
  apf_ram #(.W($bits(slot_ent_t)), .D(SLOTS)) u_slot (
    .clk(clk), .we(s_we), .waddr(s_wa), .wdata(s_wd), .raddr(s_ra), .rdata(s_rd));
  apf_ram #(.W($bits(stk_ent_t)), .D(MAX_NODES)) u_stk (
    .clk(clk), .we(k_we), .waddr(k_wa), .wdata(k_wd), .raddr(k_ra), .rdata(k_rd));

  // index of the final flag word for this node count
  logic [11:0]       nc_up;
  logic [5:0]        nwords;
  logic [WIDX_W-1:0] last_w;
  assign nc_up  = {1'b0, nc} + 12'd63;
  assign nwords = nc_up[11:6];
  assign last_w = (nwords == 6'd0) ? '0 : WIDX_W'(nwords - 6'd1);

  logic        full;
  assign full = ({1'b0, fill_r} + 15'd2) > 15'(SLOTS);

  logic [9:0]  gn, gn_prev;
  assign gn      = {gw_r, gc_r[5:0]};
  assign gn_prev = {gw_r, 6'(gc_r - 7'd1)};

  // hold state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= ST_CLEAR;
      clr_r  <= '0;
      fill_r <= '0;
      drop_r <= 1'b0;
      clk_r  <= TIME_W'(1);
      rcc_r  <= '0;
      root_r <= '0;
      sp_r   <= '0;
      gw_r   <= '0;
      gc_r   <= '0;
    end else begin
      st_r   <= st_nxt;
      clr_r  <= clr_nxt;
      fill_r <= fill_nxt;
      drop_r <= drop_nxt;
      clk_r  <= clk_nxt;
      rcc_r  <= rcc_nxt;
      root_r <= root_nxt;
      sp_r   <= sp_nxt;
      gw_r   <= gw_nxt;
      gc_r   <= gc_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    a_r     <= a_nxt;
    b_r     <= b_nxt;
    v_r     <= v_nxt;
    lowu_r  <= lowu_nxt;
    top_r   <= top_nxt;
    flags_r <= flags_nxt;
  end

  // next state and memory control
  always_comb begin
    stk_ent_t t;
    st_nxt    = st_r;
    clr_nxt   = clr_r;
    fill_nxt  = fill_r;
    drop_nxt  = drop_r;
    clk_nxt   = clk_r;
    rcc_nxt   = rcc_r;
    root_nxt  = root_r;
    sp_nxt    = sp_r;
    gw_nxt    = gw_r;
    gc_nxt    = gc_r;
    a_nxt     = a_r;
    b_nxt     = b_r;
    v_nxt     = v_r;
    lowu_nxt  = lowu_r;
    top_nxt   = top_r;
    flags_nxt = flags_r;
    t         = k_rd;
    h_we = 1'b0; h_wa = '0; h_wd = '0; h_ra = '0;
    n_we = 1'b0; n_wa = '0; n_wd = '0; n_ra = '0;
    s_we = 1'b0; s_wa = '0; s_wd = '0; s_ra = '0;
    k_we = 1'b0; k_wa = '0; k_wd = '0; k_ra = '0;
    in_rdy    = 1'b0;
    res.vld   = 1'b0;
    res.idx   = gw_r;
    res.flags = flags_r;
    res.ovf   = drop_r;
    res.last  = (gw_r == last_w);

    unique case (st_r)
      // sweep the head and node stores back to empty
      ST_CLEAR: begin
        h_we = 1'b1; h_wa = clr_r[NA-1:0]; h_wd = NIL_LINK;
        n_we = 1'b1; n_wa = clr_r[NA-1:0]; n_wd = '0;
        clr_nxt = clr_r + 1'b1;
        if (clr_r == (NA+1)'(MAX_NODES - 1)) begin
          st_nxt   = ST_IDLE;
          fill_nxt = '0;
          drop_nxt = 1'b0;
          clk_nxt  = TIME_W'(1);
        end
      end
      ST_IDLE: begin
        in_rdy = 1'b1;
        if (in_vld) begin
          if (in_act == ACT_RUN) begin
            root_nxt = '0;
            st_nxt   = ST_ROOT;
          end else if (({1'b0, in_a} >= nc) || ({1'b0, in_b} >= nc)) begin
            st_nxt = ST_IDLE;
          end else if (full) begin
            drop_nxt = 1'b1;
          end else begin
            a_nxt  = in_a;
            b_nxt  = in_b;
            st_nxt = ST_ADD_A;
          end
        end
      end
      ST_ADD_A: begin
        h_ra   = a_r[NA-1:0];
        st_nxt = ST_ADD_A2;
      end
      // link slot for direction a to b
      ST_ADD_A2: begin
        s_we = 1'b1; s_wa = fill_r[SA-1:0]; s_wd = '{far: b_r, next: h_rd};
        h_we = 1'b1; h_wa = a_r[NA-1:0];   h_wd = fill_r;
        st_nxt = ST_ADD_B;
      end
      ST_ADD_B: begin
        h_ra   = b_r[NA-1:0];
        st_nxt = ST_ADD_B2;
      end
      // link slot for direction b to a
      ST_ADD_B2: begin
        s_we = 1'b1; s_wa = SA'(fill_r + 1'b1); s_wd = '{far: a_r, next: h_rd};
        h_we = 1'b1; h_wa = b_r[NA-1:0];        h_wd = fill_r + 1'b1;
        fill_nxt = fill_r + CUR_W'(2);
        st_nxt   = ST_IDLE;
      end
      // pick the next unvisited root
      ST_ROOT: begin
        if (root_r >= nc) begin
          gw_nxt = '0;
          gc_nxt = '0;
          st_nxt = ST_GATHER;
        end else begin
          n_ra   = root_r[NA-1:0];
          h_ra   = root_r[NA-1:0];
          st_nxt = ST_ROOT_CHK;
        end
      end
      ST_ROOT_CHK: begin
        if (n_rd.visited) begin
          root_nxt = root_r + 1'b1;
          st_nxt   = ST_ROOT;
        end else begin
          n_we = 1'b1; n_wa = root_r[NA-1:0];
          n_wd = '{visited: 1'b1, cut: 1'b0, entry_t: clk_r};
          top_nxt = '{node: NODE_W'(root_r), cur: h_rd, parent: '0,
                      entry_t: clk_r, low_t: clk_r, cut: 1'b0};
          clk_nxt = clk_r + 1'b1;
          rcc_nxt = '0;
          sp_nxt  = '0;
          st_nxt  = ST_SCAN;
        end
      end
      // fetch the next adjacency slot of the top node
      ST_SCAN: begin
        if (top_r.cur < fill_r) begin
          s_ra   = top_r.cur[SA-1:0];
          st_nxt = ST_EDGE;
        end else begin
          st_nxt = ST_POP;
        end
      end
      ST_EDGE: begin
        top_nxt.cur = s_rd.next;
        if ({1'b0, s_rd.far} >= nc) begin
          st_nxt = ST_SCAN;
        end else if ((sp_r != '0) && (s_rd.far == top_r.parent)) begin
          st_nxt = ST_SCAN;
        end else begin
          n_ra   = s_rd.far[NA-1:0];
          h_ra   = s_rd.far[NA-1:0];
          v_nxt  = s_rd.far;
          st_nxt = ST_NODE;
        end
      end
      // descend into a new node or fold in a back edge
      ST_NODE: begin
        if (!n_rd.visited) begin
          if (({1'b0, sp_r} + 1'b1) < (NA+1)'(MAX_NODES)) begin
            k_we = 1'b1; k_wa = sp_r; k_wd = top_r;
            sp_nxt = sp_r + 1'b1;
            top_nxt = '{node: v_r, cur: h_rd, parent: top_r.node,
                        entry_t: clk_r, low_t: clk_r, cut: 1'b0};
            n_we = 1'b1; n_wa = v_r[NA-1:0];
            n_wd = '{visited: 1'b1, cut: 1'b0, entry_t: clk_r};
            clk_nxt = clk_r + 1'b1;
          end
        end else if (n_rd.entry_t < top_r.low_t) begin
          top_nxt.low_t = n_rd.entry_t;
        end
        st_nxt = ST_SCAN;
      end
      // retire the top node
      ST_POP: begin
        n_we = 1'b1; n_wa = top_r.node[NA-1:0];
        n_wd = '{visited: 1'b1, cut: top_r.cut, entry_t: top_r.entry_t};
        if (sp_r == '0) begin
          n_wd.cut = (rcc_r > CNT_W'(1));
          root_nxt = root_r + 1'b1;
          st_nxt   = ST_ROOT;
        end else begin
          k_ra     = sp_r - 1'b1;
          sp_nxt   = sp_r - 1'b1;
          lowu_nxt = top_r.low_t;
          st_nxt   = ST_POP2;
        end
      end
      // restore the parent and apply the low-link rule
      ST_POP2: begin
        if (lowu_r < t.low_t) begin
          t.low_t = lowu_r;
        end
        if (sp_r != '0) begin
          if (lowu_r >= k_rd.entry_t) begin
            t.cut = 1'b1;
          end
        end else begin
          rcc_nxt = rcc_r + 1'b1;
        end
        top_nxt = t;
        st_nxt  = ST_SCAN;
      end
      // read cut marks one node a cycle into the flag word
      ST_GATHER: begin
        if (gc_r < 7'd64) begin
          n_ra = gn[NA-1:0];
        end
        if (gc_r != 7'd0) begin
          flags_nxt = {n_rd.cut && ({1'b0, gn_prev} < nc), flags_r[FLAG_W-1:1]};
        end
        gc_nxt = gc_r + 1'b1;
        if (gc_r == 7'd64) begin
          st_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        res.vld = 1'b1;
        if (res_take) begin
          if (gw_r == last_w) begin
            clr_nxt = '0;
            st_nxt  = ST_CLEAR;
          end else begin
            gw_nxt = gw_r + 1'b1;
            gc_nxt = '0;
            st_nxt = ST_GATHER;
          end
        end
      end
      default: st_nxt = ST_CLEAR;
    endcase
  end

endmodule

// ===== design/articulation_point_finder.sv =====
// Top level of the articulation point finder: ports, node count register, output register.
//
// Edge transactions (tuser 0) store both directions of an undirected edge, with two
// read-modify-write passes on the list head memory. A run transaction (tuser 1) walks
// the graph depth first with the stack held in memory: each adjacency slot scanned is
// read from the slot memory and its far end, when used, looked up in the node memory;
// each node number is checked as a root and each visited node retired via the stack
// memory. Then the flag words follow, each of 64 nodes: the cut marks are read one per
// cycle and the word is handed to the output register. After reset and after every run
// a clearing pass over all MAX_NODES entries empties the node lists and marks; no input
// is accepted meanwhile. Node count writes are taken at any time and should be made while
// the block is idle.
module articulation_point_finder
  import apf_pkg::*;
#(
  parameter int MAX_NODES = DEF_MAX_NODES,
  parameter int MAX_EDGES = DEF_MAX_EDGES
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // end_a[9:0], end_b[19:10], zero pad
  input  logic                  in_tuser,   // action
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // word_index[3:0], cut_flags[67:4], overflow[68]
  output logic                  out_tlast,  // last_word
  input  logic                  cfg_we,
  input  logic [CNT_W-1:0]      cfg_wdata   // node_count
);

  logic [CNT_W-1:0]      nc_r, nc_eff;
  logic                  out_vld_r;
  logic [OUT_DATA_W-1:0] out_data_r;
  logic                  out_last_r;
  word_res_t             res;
  logic                  res_take;

  // node count register, capped at the node capacity
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nc_r <= CNT_W'(DEF_MAX_NODES);
    end else if (cfg_we) begin
      nc_r <= cfg_wdata;
    end
  end
  assign nc_eff = (nc_r > CNT_W'(MAX_NODES)) ? CNT_W'(MAX_NODES) : nc_r;

  apf_core #(.MAX_NODES(MAX_NODES), .MAX_EDGES(MAX_EDGES)) u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (in_tvalid),
    .in_act   (in_tuser),
    .in_a     (in_tdata[9:0]),
    .in_b     (in_tdata[19:10]),
    .nc       (nc_eff),
    .in_rdy   (in_tready),
    .res      (res),
    .res_take (res_take)
  );

  // load a flag word when the output register is free or draining
  assign res_take = res.vld && (!out_vld_r || out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (res_take) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_data_r <= {3'b000, res.ovf, res.flags, res.idx};
      out_last_r <= res.last;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

`ifndef SYNTHESIS
  a_rdy_excl: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !res.vld) else $error("input ready while a flag word is pending");
  a_clear_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(rst_n) |-> !in_tready) else $error("input ready before clearing pass");
  a_take_valid: assert property (@(posedge clk) disable iff (!rst_n)
    res_take |=> out_tvalid) else $error("flag word loaded but not presented");
`endif

endmodule

// ===== verif/tb_articulation_point_finder.sv =====
// Self-checking testbench for the articulation point finder: edge loads, runs, flag words.
`timescale 1ns / 1ps

module tb_articulation_point_finder;
  import apf_pkg::*;

  localparam int NMAX = DEF_MAX_NODES;
  localparam int SMAX = 2 * DEF_MAX_EDGES;

  typedef struct packed {
    logic                   act;
    logic [NODE_W-1:0]      a;
    logic [NODE_W-1:0]      b;
  } edge_cmd_t;

  typedef struct packed {
    logic [WIDX_W-1:0] idx;
    logic [FLAG_W-1:0] flags;
    logic              ovf;
    logic              last;
  } flag_word_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_DATA_W-1:0] in_tdata = '0;
  logic in_tuser = 1'b0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic out_tlast;
  logic cfg_we = 1'b0;
  logic [CNT_W-1:0] cfg_wdata = '0;

  articulation_point_finder i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  always #4 clk = ~clk;

  // Shadow of the block state
  int          nodes_in_use;
  int          slot_fill;
  bit          edge_lost;
  int          slot_far [SMAX];
  int          slot_next [SMAX];
  int          list_head [NMAX];

  edge_cmd_t   pending_cmds[$];
  flag_word_t  expected_words[$];
  int          send_idle_pct, recv_idle_pct;
  bit          recv_hold;
  bit          hold_go;
  bit          in_taken;
  int          fail_cnt;

  function automatic void clear_graph();
    for (int i = 0; i < NMAX; i++) list_head[i] = -1;
    slot_fill = 0;
    edge_lost = 0;
  endfunction

  // Walk the graph and queue the flag words one run produces
  function automatic void predict_cut_words();
    int  nc, words, sp, top, u, c, v, p, clk_t, kids;
    bit  seen [NMAX];
    bit  cut [NMAX];
    int  ent [NMAX];
    int  low [NMAX];
    int  st_node [NMAX];
    int  st_cur [NMAX];
    flag_word_t fw;
    nc = nodes_in_use;
    clk_t = 1;
    for (int i = 0; i < NMAX; i++) begin
      seen[i] = 0; cut[i] = 0; ent[i] = 0; low[i] = 0;
    end
    for (int r = 0; r < nc; r++) begin
      if (seen[r]) continue;
      kids = 0;
      seen[r] = 1; ent[r] = clk_t & 'h7FF; low[r] = ent[r]; clk_t = (clk_t + 1) & 'h7FF;
      st_node[0] = r; st_cur[0] = list_head[r];
      sp = 1;
      while (sp > 0) begin
        top = sp - 1;
        u = st_node[top];
        c = st_cur[top];
        if (c >= 0 && c < slot_fill) begin
          v = slot_far[c];
          st_cur[top] = slot_next[c];
          if (v >= nc) continue;
          if (top > 0 && v == st_node[top-1]) continue;
          if (!seen[v]) begin
            if (sp < NMAX) begin
              seen[v] = 1; ent[v] = clk_t & 'h7FF; low[v] = ent[v];
              clk_t = (clk_t + 1) & 'h7FF;
              st_node[sp] = v; st_cur[sp] = list_head[v];
              sp++;
            end
          end else if (ent[v] < low[u]) begin
            low[u] = ent[v];
          end
        end else begin
          sp--;
          if (sp > 0) begin
            p = st_node[sp-1];
            if (low[u] < low[p]) low[p] = low[u];
            if (sp - 1 > 0) begin
              if (low[u] >= ent[p]) cut[p] = 1;
            end else begin
              kids = (kids + 1) & 'h7FF;
            end
          end
        end
      end
      if (kids > 1) cut[r] = 1;
    end
    words = (nc + 63) / 64;
    if (words == 0) words = 1;
    for (int w = 0; w < words; w++) begin
      fw.idx = w[WIDX_W-1:0];
      fw.flags = '0;
      for (int i = 0; i < 64; i++)
        if (w * 64 + i < nc && cut[w * 64 + i]) fw.flags[i] = 1'b1;
      fw.ovf = edge_lost;
      fw.last = (w + 1 == words);
      expected_words.insert(expected_words.size(), fw);
    end
    clear_graph();
  endfunction

  function automatic void predict_item(edge_cmd_t cmd);
    int a, b;
    if (cmd.act == ACT_RUN) begin
      predict_cut_words();
      return;
    end
    a = cmd.a;
    b = cmd.b;
    if (a >= nodes_in_use || b >= nodes_in_use) return;
    if (slot_fill + 2 > SMAX) begin
      edge_lost = 1;
      return;
    end
    slot_far[slot_fill] = b; slot_next[slot_fill] = list_head[a];
    list_head[a] = slot_fill; slot_fill++;
    slot_far[slot_fill] = a; slot_next[slot_fill] = list_head[b];
    list_head[b] = slot_fill; slot_fill++;
  endfunction

  // Driver: present queued transactions at the falling edge
  always @(negedge clk) begin
    edge_cmd_t nxt;
    if (rst_n) begin
      if (pending_cmds.size() > 0 && ((in_tvalid && !in_taken)
          || $urandom_range(99) >= send_idle_pct)) begin
        nxt = pending_cmds[0];
        in_tvalid <= 1'b1;
        in_tuser  <= nxt.act;
        in_tdata  <= {4'b0, nxt.b, nxt.a};
      end else begin
        in_tvalid <= 1'b0;
      end
      out_tready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Monitor: predict on input transactions, check output transactions
  always @(posedge clk) begin
    edge_cmd_t  cmd;
    flag_word_t exp_w;
    if (rst_n) begin
      in_taken = in_tvalid && in_tready;
      if (in_taken) begin
        void'(pending_cmds.pop_front());
        cmd.act = in_tuser;
        cmd.a = in_tdata[9:0];
        cmd.b = in_tdata[19:10];
        predict_item(cmd);
      end
      if (out_tvalid && out_tready) begin
        if (expected_words.size() == 0) begin
          $error("unexpected flag word %h", out_tdata);
          fail_cnt++;
        end else begin
          exp_w = expected_words.pop_front();
          if (out_tdata[3:0] !== exp_w.idx) begin
            $error("word_index exp %0d got %0d", exp_w.idx, out_tdata[3:0]); fail_cnt++;
          end
          if (out_tdata[67:4] !== exp_w.flags) begin
            $error("cut_flags exp %h got %h", exp_w.flags, out_tdata[67:4]); fail_cnt++;
          end
          if (out_tdata[68] !== exp_w.ovf) begin
            $error("overflow exp %0d got %0d", exp_w.ovf, out_tdata[68]); fail_cnt++;
          end
          if (out_tlast !== exp_w.last) begin
            $error("last_word exp %0d got %0d", exp_w.last, out_tlast); fail_cnt++;
          end
        end
      end
    end
  end

  // Receiver hold: once requested, refuse output transactions for a long stretch
  initial begin
    recv_hold = 0;
    wait (hold_go);
    recv_hold = 1;
    repeat (3000) @(posedge clk);
    recv_hold = 0;
  end

  task automatic push_edge(int a, int b);
    edge_cmd_t c;
    c.act = ACT_ADD; c.a = a[NODE_W-1:0]; c.b = b[NODE_W-1:0];
    pending_cmds.insert(pending_cmds.size(), c);
  endtask

  task automatic push_run();
    edge_cmd_t c;
    c.act = ACT_RUN; c.a = NODE_W'($urandom); c.b = NODE_W'($urandom);
    pending_cmds.insert(pending_cmds.size(), c);
  endtask

  // Wait until everything is sent and every flag word has come back
  task automatic drain();
    while (pending_cmds.size() > 0 || in_tvalid || expected_words.size() > 0)
      @(posedge clk);
    repeat (2 * NMAX + 200) @(posedge clk);
  endtask

  task automatic set_node_count(int n);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= n[CNT_W-1:0];
    @(negedge clk);
    cfg_we <= 1'b0;
    nodes_in_use = (n > NMAX) ? NMAX : n;
  endtask

  // Random graph of n nodes: chains and cycles with random chords and some noise
  task automatic push_random_graph(int n, int edges);
    int a, b;
    for (int i = 0; i < edges; i++) begin
      case ($urandom_range(9))
        0: begin a = $urandom_range(1023); b = $urandom_range(1023); end
        1: begin a = $urandom_range(n - 1); b = a; end
        2, 3, 4: begin a = $urandom_range(n - 1); b = (a + 1) % n; end
        default: begin a = $urandom_range(n - 1); b = $urandom_range(n - 1); end
      endcase
      push_edge(a, b);
    end
    push_run();
  endtask

  initial begin
    nodes_in_use = NMAX;
    clear_graph();
    fail_cnt = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset node count, empty graph, then a path and a bridge pair
    push_run();
    push_edge(0, 1); push_edge(1, 2); push_edge(2, 3); push_edge(3, 3);
    push_edge(1, 2); push_edge(1023, 1022); push_edge(1023, 0);
    push_run();
    drain();

    set_node_count(6);
    // Triangle with tail, out-of-range ends, self loop, parallel edges
    push_edge(0, 1); push_edge(1, 2); push_edge(2, 0); push_edge(2, 3);
    push_edge(3, 4); push_edge(3, 4); push_edge(6, 1); push_edge(1, 1023);
    push_edge(5, 5);
    push_run();
    drain();

    set_node_count(0);
    push_edge(0, 0);
    push_run();
    drain();

    // Shrunk count: stored neighbours at or above the new count are ignored
    set_node_count(1024);
    push_edge(0, 1); push_edge(1, 2); push_edge(2, 700);
    drain();
    set_node_count(2);
    push_run();
    drain();

    // Random phases at three idle settings
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 24 : (ph == 1) ? 72 : 0;
      recv_idle_pct = (ph == 0) ? 72 : (ph == 1) ? 24 : 0;
      for (int g = 0; g < 3; g++) begin
        int n;
        n = (g == 2 && ph == 2) ? 1024 : $urandom_range(3, 100);
        if (ph == 1 && g == 0) n = 1;
        set_node_count(n);
        push_random_graph(n, $urandom_range(15, 45));
        if (ph == 0 && g == 1) begin
          // Long receiver hold while edges and runs keep coming
          hold_go = 1;
          push_random_graph(n, 10);
          push_random_graph(n, 10);
        end
        drain();
      end
    end

    drain();
    if (fail_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #50ms;
    $display("TB_ERROR");
    $finish;
  end

endmodule
